// ===== hw/rtl/lprd_pkg.sv =====
// Shared types and constants for the length-prefixed request deframer.
package lprd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned WordWidth   = 32;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned LimitWidth  = 16;
   localparam int unsigned HeaderBytes = 4;

   localparam logic [WordWidth-1:0]  MinFrameLen    = 32'd12;
   localparam logic [WordWidth-1:0]  HeartBeatValue = 32'd0;
   localparam logic [LimitWidth-1:0] LimitReset     = 16'd1024;

   // Content byte offsets where the id, low and high words end.
   localparam logic [CountWidth-1:0] IdEnd   = 16'd4;
   localparam logic [CountWidth-1:0] LowEnd  = 16'd8;
   localparam logic [CountWidth-1:0] HighEnd = 16'd12;

   localparam logic [CountWidth-1:0] HeaderLast = 16'(HeaderBytes - 1);

   typedef enum logic [1:0] {
      KIND_INTEGER   = 2'd0,
      KIND_UNIT      = 2'd1,
      KIND_HEARTBEAT = 2'd2,
      KIND_LEN_ERROR = 2'd3
   } frame_kind_type;

   typedef struct packed {
      logic [WordWidth-1:0] frame_length;
      logic [WordWidth-1:0] range_high;
      logic [WordWidth-1:0] range_low;
      logic [WordWidth-1:0] request_id;
   } rsp_data_type;

endpackage

// ===== hw/rtl/length_prefixed_request_deframer.sv =====
// Top level of the length-prefixed request deframer: byte parser and result register.
//
//   channel  | direction | tdata fields (low bit up)                     | tuser
//   req      | in        | rx_byte[7:0]                                  | -
//   rsp      | out       | request_id, range_low, range_high,            | frame_kind
//            |           | frame_length (32 bits each, 128 total)        |
//   csr      | in        | length_limit[15:0] on csr_wr_data             | -
//
// Cycles: one byte beat is taken every clock while req_tready is high; a result appears on rsp
// in the cycle after the beat that closes a header (length error) or a frame. The parse
// state registers feed one pass of compare and shift logic into the result register.
// Reset clears the parse state, the result valid flag and restores length_limit to 1024.
// Stalls: req_tready drops only while a result is held and rsp_tready is low;
// a waiting result is handed off and the next byte taken in the same cycle.
module length_prefixed_request_deframer (
   input  logic                          clock,
   input  logic                          reset,
   // rx_byte[7:0]
   input  logic [lprd_pkg::ByteWidth-1:0]  req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // request_id[31:0], range_low[63:32], range_high[95:64], frame_length[127:96]
   output logic [4*lprd_pkg::WordWidth-1:0] rsp_tdata,
   // frame_kind[1:0]
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_wr_en,
   input  logic [lprd_pkg::LimitWidth-1:0] csr_wr_data
);
   import lprd_pkg::*;

   // Parse state
   logic                    in_content_ff, in_content_in;
   logic [WordWidth-1:0]    length_word_ff, length_word_in;
   logic [CountWidth-1:0]   byte_count_ff, byte_count_in;
   logic [WordWidth-1:0]    id_word_ff, id_word_in;
   logic [WordWidth-1:0]    low_word_ff, low_word_in;
   logic [WordWidth-1:0]    high_word_ff, high_word_in;
   logic [LimitWidth-1:0]   length_limit_ff;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   frame_kind_type          rsp_kind_ff, rsp_kind_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic                    emit;
   logic [CountWidth-1:0]   count_inc;
   logic [WordWidth-1:0]    length_shift;
   logic [WordWidth-1:0]    id_next, low_next, high_next;
   logic                    length_bad;
   frame_kind_type          frame_kind;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign count_inc    = byte_count_ff + 1'b1;
   assign length_shift = {length_word_ff[WordWidth-ByteWidth-1:0], req_tdata};
   assign length_bad   = (length_shift < MinFrameLen) ||
                         (length_shift >= {{(WordWidth-LimitWidth){1'b0}}, length_limit_ff});

   // Shift the content byte into whichever word it belongs to; drop bytes past the twelfth.
   always_comb begin
      id_next   = id_word_ff;
      low_next  = low_word_ff;
      high_next = high_word_ff;
      if (byte_count_ff < IdEnd) begin
         id_next = {id_word_ff[WordWidth-ByteWidth-1:0], req_tdata};
      end else if (byte_count_ff < LowEnd) begin
         low_next = {low_word_ff[WordWidth-ByteWidth-1:0], req_tdata};
      end else if (byte_count_ff < HighEnd) begin
         high_next = {high_word_ff[WordWidth-ByteWidth-1:0], req_tdata};
      end
   end

   always_comb begin
      if (low_next == HeartBeatValue && high_next == HeartBeatValue) begin
         frame_kind = KIND_HEARTBEAT;
      end else if (low_next == 32'd0 && high_next == 32'd1) begin
         frame_kind = KIND_UNIT;
      end else begin
         frame_kind = KIND_INTEGER;
      end
   end

   always_comb begin
      in_content_in  = in_content_ff;
      length_word_in = length_word_ff;
      byte_count_in  = byte_count_ff;
      id_word_in     = id_word_ff;
      low_word_in    = low_word_ff;
      high_word_in   = high_word_ff;
      emit           = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_data_in    = rsp_data_ff;

      if (req_accept) begin
         if (!in_content_ff) begin
            // Header phase: gather the big-endian length word.
            length_word_in = length_shift;
            byte_count_in  = count_inc;
            if (byte_count_ff == HeaderLast) begin
               byte_count_in = '0;
               if (length_bad) begin
                  emit                     = 1'b1;
                  rsp_kind_in              = KIND_LEN_ERROR;
                  rsp_data_in.request_id   = '0;
                  rsp_data_in.range_low    = '0;
                  rsp_data_in.range_high   = '0;
                  rsp_data_in.frame_length = length_shift;
                  length_word_in           = '0;
               end else begin
                  in_content_in = 1'b1;
                  id_word_in    = '0;
                  low_word_in   = '0;
                  high_word_in  = '0;
               end
            end
         end else begin
            // Content phase: gather words, close the frame on its last byte.
            id_word_in    = id_next;
            low_word_in   = low_next;
            high_word_in  = high_next;
            byte_count_in = count_inc;
            if ({{(WordWidth-CountWidth){1'b0}}, count_inc} >= length_word_ff) begin
               emit                     = 1'b1;
               rsp_kind_in              = frame_kind;
               rsp_data_in.request_id   = id_next;
               rsp_data_in.range_low    = low_next;
               rsp_data_in.range_high   = high_next;
               rsp_data_in.frame_length = length_word_ff;
               in_content_in            = 1'b0;
               length_word_in           = '0;
               byte_count_in            = '0;
               id_word_in               = '0;
               low_word_in              = '0;
               high_word_in             = '0;
            end
         end
      end

      // Hold the result until taken; load a fresh one on emit.
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_content_ff   <= 1'b0;
         length_word_ff  <= '0;
         byte_count_ff   <= '0;
         id_word_ff      <= '0;
         low_word_ff     <= '0;
         high_word_ff    <= '0;
         length_limit_ff <= LimitReset;
         rsp_valid_ff    <= 1'b0;
      end else begin
         in_content_ff  <= in_content_in;
         length_word_ff <= length_word_in;
         byte_count_ff  <= byte_count_in;
         id_word_ff     <= id_word_in;
         low_word_ff    <= low_word_in;
         high_word_ff   <= high_word_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            length_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Header phase never counts past the fourth length byte.
   assert property (@(posedge clock) disable iff (reset)
      !in_content_ff |-> byte_count_ff < 16'(HeaderBytes))
      else $error("header byte count overran");

   // In a frame the count stays below an accepted length of at least twelve.
   assert property (@(posedge clock) disable iff (reset)
      in_content_ff |-> (length_word_ff >= MinFrameLen) &&
                        ({{(WordWidth-CountWidth){1'b0}}, byte_count_ff} < length_word_ff))
      else $error("content count beyond frame length");

   // A length error carries zero words; a frame result carries a length of at least twelve.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_LEN_ERROR |->
         rsp_data_ff.request_id == '0 && rsp_data_ff.range_low == '0 &&
         rsp_data_ff.range_high == '0)
      else $error("length error result with nonzero words");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_LEN_ERROR |->
         rsp_data_ff.frame_length >= MinFrameLen)
      else $error("frame result with short length");

   // Heartbeat classification matches the words it reports.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_HEARTBEAT |->
         rsp_data_ff.range_low == HeartBeatValue && rsp_data_ff.range_high == HeartBeatValue)
      else $error("heartbeat with nonzero range");

endmodule
